>>> sv/suks_pkg.sv
// Shared types and constants for the sorted unique key set.
// Used by the controller, the top level and the port checker; no dependencies.
`default_nettype none

package suks_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 10;

	localparam logic [KEY_W-1:0] KEY_MIN = KEY_W'(1);
	localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(999);
	localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LIST   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_ADDED    = 3'd0,
		S_DUP      = 3'd1,
		S_FULL     = 3'd2,
		S_REMOVED  = 3'd3,
		S_NOTFOUND = 3'd4,
		S_LISTED   = 3'd5,
		S_EMPTY    = 3'd6
	} status_t;

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] entry_key;
		logic             last;
	} res_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [KEY_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} ram_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_EV,
		ST_INS_RD,
		ST_INS_EV,
		ST_DEL_RD,
		ST_DEL_EV,
		ST_LIST_RD,
		ST_LIST_EV
	} state_t;

endpackage

`default_nettype wire

>>> sv/suks_ram.sv
// Generic simple dual-port synchronous RAM with a registered read port.
// No package dependencies.
`default_nettype none

module suks_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 10
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/suks_ctrl.sv
// Sequencer for the sorted key set: search, shift-insert, shift-delete and list.
// Depends on suks_pkg; drives the key RAM through a ram_cmd_t bundle.
`default_nettype none

module suks_ctrl
	import suks_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire req_t             req,
	output logic                  busy,
	output ram_cmd_t              ram_cmd,
	input  wire logic [KEY_W-1:0] ram_rdata,
	output logic                  res_strobe,
	output res_t                  res
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic             is_add_q, is_add_d;
	logic             emit;
	res_t             emit_res;
	logic             miss;
	logic [CNT_W-1:0] ptr_inc, ptr_dec;
	logic             res_strobe_q;
	res_t             res_q;

	assign ptr_inc = ptr_q + CNT_W'(1);
	assign ptr_dec = ptr_q - CNT_W'(1);
	assign busy = (state_q != ST_IDLE);
	assign res_strobe = res_strobe_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			res_strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		pos_q <= pos_d;
		key_q <= key_d;
		is_add_q <= is_add_d;
		if (emit) begin
			res_q <= emit_res;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d = ptr_q;
		pos_d = pos_q;
		key_d = key_q;
		is_add_d = is_add_q;
		emit = 1'b0;
		emit_res = '{status: S_ADDED, entry_key: key_q, last: 1'b1};
		ram_cmd = '{we: 1'b0, waddr: ptr_q[IDX_W-1:0], wdata: ram_rdata,
			raddr: ptr_q[IDX_W-1:0]};
		miss = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_d = req.key;
					is_add_d = (req.kind == KIND_ADD);
					ptr_d = '0;
					unique case (req.kind)
						KIND_LIST: begin
							if (count_q == '0) begin
								emit = 1'b1;
								emit_res = '{status: S_EMPTY, entry_key: '0, last: 1'b1};
							end else begin
								state_d = ST_LIST_RD;
							end
						end
						KIND_ADD, KIND_REMOVE: begin
							if (req.key >= KEY_MIN && req.key <= KEY_MAX) begin
								state_d = ST_SRCH_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SRCH_RD: begin
				if (ptr_q == count_q) begin
					miss = 1'b1;
				end else begin
					state_d = ST_SRCH_EV;
				end
			end
			ST_SRCH_EV: begin
				priority if (ram_rdata < key_q) begin
					ptr_d = ptr_inc;
					state_d = ST_SRCH_RD;
				end else if (ram_rdata == key_q) begin
					if (is_add_q) begin
						emit = 1'b1;
						emit_res.status = S_DUP;
						state_d = ST_IDLE;
					end else begin
						ptr_d = ptr_inc;
						state_d = ST_DEL_RD;
					end
				end else begin
					miss = 1'b1;
				end
			end
			ST_INS_RD: begin
				// ptr_q is the destination slot; entries above the insert point move up.
				if (ptr_q == pos_q) begin
					ram_cmd.we = 1'b1;
					ram_cmd.wdata = key_q;
					count_d = count_q + CNT_W'(1);
					emit = 1'b1;
					emit_res.status = S_ADDED;
					state_d = ST_IDLE;
				end else begin
					ram_cmd.raddr = ptr_dec[IDX_W-1:0];
					state_d = ST_INS_EV;
				end
			end
			ST_INS_EV: begin
				ram_cmd.we = 1'b1;
				ptr_d = ptr_dec;
				state_d = ST_INS_RD;
			end
			ST_DEL_RD: begin
				// ptr_q is the source slot; entries above the removed key move down.
				if (ptr_q == count_q) begin
					count_d = count_q - CNT_W'(1);
					emit = 1'b1;
					emit_res.status = S_REMOVED;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DEL_EV;
				end
			end
			ST_DEL_EV: begin
				ram_cmd.we = 1'b1;
				ram_cmd.waddr = ptr_dec[IDX_W-1:0];
				ptr_d = ptr_inc;
				state_d = ST_DEL_RD;
			end
			ST_LIST_RD: begin
				state_d = ST_LIST_EV;
			end
			ST_LIST_EV: begin
				emit = 1'b1;
				emit_res = '{status: S_LISTED, entry_key: ram_rdata,
					last: (ptr_inc == count_q)};
				if (ptr_inc == count_q) begin
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_inc;
					state_d = ST_LIST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// The key is absent and ptr_q is where it belongs.
		if (miss) begin
			if (!is_add_q) begin
				emit = 1'b1;
				emit_res.status = S_NOTFOUND;
				state_d = ST_IDLE;
			end else if (count_q == COUNT_FULL) begin
				emit = 1'b1;
				emit_res.status = S_FULL;
				state_d = ST_IDLE;
			end else begin
				pos_d = ptr_q;
				ptr_d = count_q;
				state_d = ST_INS_RD;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/sorted_unique_key_set_core.sv
// Sorted unique key set: keys live in one synchronous RAM; each access step is a read state then an evaluate state.
// Add/remove: search up to the key, then shift the tail.
// List: one result per stored key, in ascending order; an empty set gives an empty status in the cycle after start.
// Out-of-range keys and unknown kinds finish at once with no transaction on res.
// arst_n clears the count, the controller state and res_strobe; RAM contents are not cleared.
// busy is low again in the cycle that shows the final result; the receiver cannot stall.
`default_nettype none

module sorted_unique_key_set_core
	import suks_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      res_strobe,
	output res_t      res
);

	ram_cmd_t         ram_cmd;
	logic [KEY_W-1:0] ram_rdata;

	suks_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.ram_cmd    (ram_cmd),
		.ram_rdata  (ram_rdata),
		.res_strobe (res_strobe),
		.res        (res)
	);

	suks_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_cmd.we),
		.waddr (ram_cmd.waddr),
		.wdata (ram_cmd.wdata),
		.raddr (ram_cmd.raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> sv/suks_checker.sv
// Port-level checks for sorted_unique_key_set_core, attached by bind.
// Depends on suks_pkg.
`default_nettype none

module suks_checker
	import suks_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire req_t req,
	input wire logic busy,
	input wire logic res_strobe,
	input wire res_t res
);

	// A valid add or remove always starts a search.
	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.kind == KIND_ADD || req.kind == KIND_REMOVE)
		&& req.key >= KEY_MIN && req.key <= KEY_MAX |=> busy)
		else $error("valid add/remove did not start work");

	// A list transaction either reports empty next cycle or keeps the block busy.
	a_list_responds: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind == KIND_LIST |=> (res_strobe || busy))
		else $error("list transaction dropped");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.status != S_LISTED |-> res.last)
		else $error("single result without last");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.last |-> !busy)
		else $error("still busy after final result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.status == S_EMPTY |-> res.entry_key == '0)
		else $error("empty status with nonzero key");

endmodule

bind sorted_unique_key_set_core suks_checker u_suks_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.req        (req),
	.busy       (busy),
	.res_strobe (res_strobe),
	.res        (res)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for sorted_unique_key_set_core: add, remove and list transactions
// are predicted by a scoreboard class that keeps its own copy of the key set.
// Depends on suks_pkg for the request and result types and the key limits.
`default_nettype none

module tb;
	import suks_pkg::*;

	localparam int         LIMIT_CYCLES = 300000;
	localparam int         DRAIN_CYCLES = 2 * CAPACITY + 16;
	localparam logic [1:0] KIND_RSVD    = 2'd3;
	localparam logic [KEY_W-1:0] KEY_TOP = '1;

	class key_set_scoreboard;
		logic [KEY_W-1:0] set_keys[CAPACITY];
		int               set_count;
		res_t             due_results[$];
		int               fails;

		function new();
			set_count = 0;
			fails = 0;
		endfunction

		function res_t make_result(status_t s, logic [KEY_W-1:0] k, logic l);
			res_t r;
			r.status = s;
			r.entry_key = k;
			r.last = l;
			return r;
		endfunction

		// Applies one accepted request to the key set and queues the results it causes.
		function void note_request(req_t r);
			int  pos;
			bit  hit;
			bit  op_ok;
			op_ok = (r.kind == KIND_ADD || r.kind == KIND_REMOVE)
				&& r.key >= KEY_MIN && r.key <= KEY_MAX;
			if (r.kind == KIND_LIST) begin
				if (set_count == 0)
					due_results.push_back(make_result(S_EMPTY, '0, 1'b1));
				for (int i = 0; i < set_count; i++)
					due_results.push_back(make_result(S_LISTED, set_keys[i],
						i == set_count - 1));
			end else if (op_ok) begin
				pos = 0;
				while (pos < set_count && set_keys[pos] < r.key)
					pos++;
				hit = pos < set_count && set_keys[pos] == r.key;
				if (r.kind == KIND_ADD) begin
					// A stored key reports a duplicate even when the set is full.
					if (hit) begin
						due_results.push_back(make_result(S_DUP, r.key, 1'b1));
					end else if (set_count >= CAPACITY) begin
						due_results.push_back(make_result(S_FULL, r.key, 1'b1));
					end else begin
						for (int i = set_count; i > pos; i--)
							set_keys[i] = set_keys[i - 1];
						set_keys[pos] = r.key;
						set_count++;
						due_results.push_back(make_result(S_ADDED, r.key, 1'b1));
					end
				end else if (hit) begin
					for (int i = pos; i + 1 < set_count; i++)
						set_keys[i] = set_keys[i + 1];
					set_count--;
					due_results.push_back(make_result(S_REMOVED, r.key, 1'b1));
				end else begin
					due_results.push_back(make_result(S_NOTFOUND, r.key, 1'b1));
				end
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d, entry_key %0d, last %0d",
					got.status, got.entry_key, got.last);
				fails++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				fails++;
			end
			if (got.entry_key !== want.entry_key) begin
				$error("entry_key: expected %0d, actual %0d", want.entry_key, got.entry_key);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic res_strobe;
	res_t res;

	key_set_scoreboard sb = new();
	int cycles = 0;

	sorted_unique_key_set_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.res_strobe(res_strobe),
		.res(res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_strobe)
			sb.check_result(res);
	end

	function automatic req_t mk(logic [1:0] kind, logic [KEY_W-1:0] key);
		req_t r;
		r.kind = kind_t'(kind);
		r.key = key;
		return r;
	endfunction

	// Keys already in the set (stored_pct) or from a small pool (pool), so hits and duplicates are common.
	function automatic logic [KEY_W-1:0] pick_key(int stored_pct, int pool);
		int r;
		r = $urandom_range(0, 99);
		if (sb.set_count > 0 && r < stored_pct)
			return sb.set_keys[$urandom_range(0, sb.set_count - 1)];
		if (r >= 95)
			return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
		if (pool > 0)
			return KEY_W'($urandom_range(1, pool));
		return KEY_W'($urandom_range(KEY_MIN, KEY_MAX));
	endfunction

	function automatic req_t random_item(int add_pct, int rem_pct, int list_pct,
		int stored_pct, int pool);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			return mk(KIND_ADD, pick_key(stored_pct, pool));
		if (r < add_pct + rem_pct)
			return mk(KIND_REMOVE, pick_key(stored_pct, pool));
		if (r < add_pct + rem_pct + list_pct)
			return mk(KIND_LIST, KEY_W'($urandom_range(0, KEY_TOP)));
		// Noise: reserved kind, or an add or remove with a key out of range.
		case ($urandom_range(0, 2))
			0: return mk(KIND_RSVD, KEY_W'($urandom_range(0, KEY_TOP)));
			1: return mk($urandom_range(0, 1) ? KIND_ADD : KIND_REMOVE, '0);
			default: return mk($urandom_range(0, 1) ? KIND_ADD : KIND_REMOVE,
				KEY_W'($urandom_range(KEY_MAX + 1, KEY_TOP)));
		endcase
	endfunction

	function automatic int pick_gap(bit quiet);
		if (quiet || $urandom_range(0, 99) >= 30)
			return 0;
		return $urandom_range(1, 15);
	endfunction

	// Holds start high until the block takes the transaction, then books it.
	task automatic send_item(req_t r, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic run_segment(int n, int add_pct, int rem_pct, int list_pct,
		int stored_pct, int pool, int quiet_tail);
		bit quiet;
		quiet = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 10 == 0)
				quiet = $urandom_range(0, 3) == 0;
			send_item(random_item(add_pct, rem_pct, list_pct, stored_pct, pool),
				pick_gap(quiet || i >= n - quiet_tail));
		end
	endtask

	initial begin
		req_t directed[$];
		directed = '{
			mk(KIND_LIST, KEY_TOP),
			mk(KIND_REMOVE, KEY_MIN),
			mk(KIND_ADD, 10'd500),
			mk(KIND_ADD, KEY_MAX),
			mk(KIND_ADD, KEY_MIN),
			mk(KIND_ADD, 10'd500),
			mk(KIND_LIST, '0),
			mk(KIND_ADD, '0),
			mk(KIND_ADD, 10'd1000),
			mk(KIND_ADD, KEY_TOP),
			mk(KIND_REMOVE, '0),
			mk(KIND_REMOVE, KEY_TOP),
			mk(KIND_RSVD, 10'd5),
			mk(KIND_RSVD, KEY_TOP),
			mk(KIND_REMOVE, KEY_MAX),
			mk(KIND_REMOVE, KEY_MAX),
			mk(KIND_ADD, 10'd341),
			mk(KIND_ADD, 10'd682),
			mk(KIND_LIST, 10'd682),
			mk(KIND_REMOVE, KEY_MIN),
			mk(KIND_REMOVE, 10'd500),
			mk(KIND_REMOVE, 10'd341),
			mk(KIND_REMOVE, 10'd682),
			mk(KIND_LIST, KEY_TOP)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i], pick_gap(1'b0));

		// Churn on a small key pool, then fill past capacity, then drain.
		run_segment(80, 45, 30, 15, 40, 40, 0);
		run_segment(100, 80, 5, 10, 20, 0, 0);
		run_segment(100, 15, 60, 20, 70, 0, 40);

		// Drop start at the edge that took the last transaction so it is not taken twice.
		start <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.due_results.size() != 0)
			$error("%0d results never arrived", sb.due_results.size());
		if (sb.fails == 0 && sb.due_results.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
